### sv/slq_pkg.sv
`timescale 1ns / 1ps

package slq_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int EC_W     = 5;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;

  // transaction action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_SORTED     = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_LEFT
  } cell_op_e;

  // where an insert lands
  typedef enum logic [1:0] {
    INS_SORTED,
    INS_FRONT,
    INS_BACK
  } ins_mode_e;

  // command broadcast to the whole cell row
  typedef struct packed {
    cell_op_e                  op;
    ins_mode_e                 mode;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

### sv/slq_in_if.sv
`timescale 1ns / 1ps

interface slq_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic signed [31:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

### sv/slq_out_if.sv
`timescale 1ns / 1ps

interface slq_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  removed_value;
  logic                removed_valid;
  logic [1:0]          status;
  logic [4:0]          entry_count;

  modport source (
    output valid, output removed_value, output removed_valid, output status,
    output entry_count, input ready
  );
  modport sink (
    input valid, input removed_value, input removed_valid, input status,
    input entry_count, output ready
  );
endinterface

### sv/sorted_list_deque_unit.sv
`timescale 1ns / 1ps

// Bounded list of signed 32-bit values, kept head to tail in a row of cells.
// in_i carries one transaction per item: an action (sorted insert, push
// front, push back, pop front, pop back) and a value. out_o returns exactly
// one result per item: the popped value and its valid flag, a status (done,
// insert dropped on a full list, pop on an empty list) and the entry count.
// Every cell compares its entry with the new value and shifts toward the
// tail or the head in the same cycle: an item's result is loaded into the
// output register at the accepting edge and offered on out_o in the next
// cycle, and a new item is accepted every cycle while the receiver keeps
// up. The output register is the only buffer: while a result waits
// (out_o.valid high, out_o.ready low) in_i.ready is low and the list holds
// still. Reset (rst_ni low, asynchronous) empties the list and drops any
// pending result; entry contents are not cleared, they are only read below
// the count.
module sorted_list_deque_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  slq_in_if.sink     in_i,
  slq_out_if.source  out_o
);
  import slq_pkg::*;

  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;
  logic                     fire;
  logic                     full;
  logic                     empty;
  logic [IDX_W-1:0]         last_idx;
  cell_cmd_t                cmd;
  status_e                  status;
  logic signed [DATA_W-1:0] rm_value;
  logic                     rm_valid;

  logic signed [DATA_W-1:0] cell_entry [CAPACITY];
  logic                     cell_stop  [CAPACITY];

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] rm_value_q;
  logic                     rm_valid_q;
  status_e                  status_q;
  logic [CNT_W-1:0]         count_out_q;

  // handshake: take a transaction when the output register is free
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign fire       = in_i.valid & in_i.ready;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign last_idx = IDX_W'(count_q - CNT_W'(1));

  // decode action into a row command and the result
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.mode  = INS_SORTED;
    cmd.value = in_i.value;
    status    = ST_DONE;
    rm_value  = '0;
    rm_valid  = 1'b0;
    count_d   = count_q;
    if (fire) begin
      case (action_e'(in_i.action))
        ACT_SORTED, ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cmd.op  = CELL_INSERT;
            count_d = count_q + CNT_W'(1);
            case (action_e'(in_i.action))
              ACT_PUSH_FRONT: cmd.mode = INS_FRONT;
              ACT_PUSH_BACK:  cmd.mode = INS_BACK;
              default:        cmd.mode = INS_SORTED;
            endcase
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            cmd.op   = CELL_SHIFT_LEFT;
            rm_value = cell_entry[0];
            rm_valid = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rm_value = cell_entry[last_idx];
            rm_valid = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
        default: status = ST_DONE;
      endcase
    end
  end

  // row of cells, head at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_entry;
    logic                     left_stop;
    logic signed [DATA_W-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_entry = in_i.value;
      assign left_stop  = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_stop  = cell_stop[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    slq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .valid_i       (CNT_W'(i) < count_q),
      .left_entry_i  (left_entry),
      .left_stop_i   (left_stop),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .stop_o        (cell_stop[i])
    );
  end

  // occupancy and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rm_value_q  <= rm_value;
      rm_valid_q  <= rm_valid;
      status_q    <= status;
      count_out_q <= count_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = rm_value_q;
  assign out_o.removed_valid = rm_valid_q;
  assign out_o.status        = status_q;
  assign out_o.entry_count   = EC_W'(count_out_q);

endmodule

### sv/slq_cell.sv
`timescale 1ns / 1ps

module slq_cell (
  input  logic                              clk_i,
  input  slq_pkg::cell_cmd_t                cmd_i,
  input  logic                              valid_i,
  input  logic signed [slq_pkg::DATA_W-1:0] left_entry_i,
  input  logic                              left_stop_i,
  input  logic signed [slq_pkg::DATA_W-1:0] right_entry_i,
  output logic signed [slq_pkg::DATA_W-1:0] entry_o,
  output logic                              stop_o
);
  import slq_pkg::*;

  logic signed [DATA_W-1:0] entry_q;
  logic signed [DATA_W-1:0] entry_d;
  logic                     pass;

  // new value passes this cell when it must go further toward the tail
  always_comb begin
    case (cmd_i.mode)
      INS_SORTED: pass = valid_i && (entry_q < cmd_i.value);
      INS_BACK:   pass = valid_i;
      default:    pass = 1'b0;
    endcase
  end

  // insert point is at or before this cell
  assign stop_o = left_stop_i | ~pass;

  // next entry: take left neighbor, take new value, take right neighbor or hold
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (left_stop_i) begin
          entry_d = left_entry_i;
        end else if (!pass) begin
          entry_d = cmd_i.value;
        end
      end
      CELL_SHIFT_LEFT: entry_d = right_entry_i;
      default:         entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### tb/tb_sorted_list_deque_unit.sv
`timescale 1ns / 1ps

module tb_sorted_list_deque_unit;
  import slq_pkg::*;

  // action codes the block ignores
  localparam logic [ACT_W-1:0] ACT_RSVD_5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 5;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic                     removed_valid;
    status_e                  status;
    logic [EC_W-1:0]          entry_count;
  } list_result_t;

  typedef struct packed {
    logic [ACT_W-1:0]         act;
    logic signed [DATA_W-1:0] val;
    bit                       fixed;
    list_result_t             res;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  slq_in_if  in_if ();
  slq_out_if out_if ();

  sorted_list_deque_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state: list contents head to tail
  logic signed [DATA_W-1:0] held_values[$];
  list_result_t             list_results_q[$];
  stim_row_t                directed_rows[$];

  int send_idle_pct = 20;
  int recv_idle_pct = 59;
  int stall_cycles  = 0;
  bit mismatch_seen = 1'b0;

  always #2 clk_i = ~clk_i;

  initial begin
    in_if.valid   = 1'b0;
    in_if.action  = '0;
    in_if.value   = '0;
    out_if.ready  = 1'b0;
  end

  // apply one action to the predicted list and return its result
  function automatic list_result_t list_apply(input logic [ACT_W-1:0] act,
                                              input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int           pos;
    res        = '0;
    res.status = ST_DONE;
    case (act)
      ACT_SORTED, ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (held_values.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (act == ACT_PUSH_FRONT) begin
          held_values.push_front(val);
        end else if (act == ACT_PUSH_BACK) begin
          held_values.push_back(val);
        end else begin
          // before the first entry not less than the value, so a new value goes ahead of equal ones
          pos = 0;
          while (pos < held_values.size() && held_values[pos] < val) pos++;
          held_values.insert(pos, val);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (held_values.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_valid = 1'b1;
          res.removed_value = (act == ACT_POP_FRONT) ? held_values.pop_front()
                                                     : held_values.pop_back();
        end
      end
      default: ;
    endcase
    res.entry_count = EC_W'(held_values.size());
    return res;
  endfunction

  function automatic stim_row_t pred_row(input logic [ACT_W-1:0] act,
                                         input logic signed [DATA_W-1:0] val);
    stim_row_t r;
    r       = '0;
    r.act   = act;
    r.val   = val;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input logic [ACT_W-1:0] act,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic signed [DATA_W-1:0] rv,
                                          input logic rvld, input status_e st,
                                          input int cnt);
    stim_row_t r;
    r                   = '0;
    r.act               = act;
    r.val               = val;
    r.fixed             = 1'b1;
    r.res.removed_value = rv;
    r.res.removed_valid = rvld;
    r.res.status        = st;
    r.res.entry_count   = EC_W'(cnt);
    return r;
  endfunction

  // offer one transaction, with a random gap first, and predict it on acceptance
  task automatic send_item(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] val,
                           input bit fixed, input list_result_t fixed_res);
    list_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.value  <= val;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    pred = list_apply(act, val);
    list_results_q.push_back(fixed ? fixed_res : pred);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (list_results_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (list_results_q.size() == 0) begin
        $error("unexpected result: removed_value %0d status %0d entry_count %0d",
               out_if.removed_value, out_if.status, out_if.entry_count);
        mismatch_seen = 1'b1;
      end else begin
        want = list_results_q.pop_front();
        if (out_if.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, got %0d", want.removed_value,
                 out_if.removed_value);
          mismatch_seen = 1'b1;
        end
        if (out_if.removed_valid !== want.removed_valid) begin
          $error("removed_valid: expected %0d, got %0d", want.removed_valid,
                 out_if.removed_valid);
          mismatch_seen = 1'b1;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatch_seen = 1'b1;
        end
        if (out_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_if.entry_count);
          mismatch_seen = 1'b1;
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** sorted_list_deque_unit: FAILED **");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [ACT_W-1:0]         act;
    logic signed [DATA_W-1:0] val;
    int                       roll;
    bit                       filling;

    // empty pops, ignored codes, extremes, equal values, fill to full, full inserts, pops
    directed_rows = '{
      fixed_row(ACT_POP_FRONT, 32'sd55, 0, 1'b0, ST_EMPTY, 0),
      fixed_row(ACT_POP_BACK, -32'sd1, 0, 1'b0, ST_EMPTY, 0),
      fixed_row(ACT_RSVD_5, 32'sd7, 0, 1'b0, ST_DONE, 0),
      fixed_row(ACT_RSVD_6, 32'sh7FFFFFFF, 0, 1'b0, ST_DONE, 0),
      fixed_row(ACT_RSVD_7, 32'sh80000000, 0, 1'b0, ST_DONE, 0),
      fixed_row(ACT_SORTED, 32'sh7FFFFFFF, 0, 1'b0, ST_DONE, 1),
      fixed_row(ACT_SORTED, 32'sh80000000, 0, 1'b0, ST_DONE, 2),
      pred_row(ACT_SORTED, 32'sd0),
      pred_row(ACT_SORTED, 32'sd0),
      pred_row(ACT_PUSH_FRONT, 32'sh7FFFFFFF),
      pred_row(ACT_PUSH_BACK, 32'sh80000000),
      pred_row(ACT_SORTED, -32'sd1),
      pred_row(ACT_SORTED, 32'sd1),
      pred_row(ACT_PUSH_BACK, 32'sh55555555),
      pred_row(ACT_PUSH_FRONT, 32'shAAAAAAAA),
      pred_row(ACT_SORTED, 32'sh12345678),
      pred_row(ACT_SORTED, -32'sd100),
      pred_row(ACT_PUSH_BACK, 32'sd3),
      pred_row(ACT_SORTED, 32'sh7FFFFFFF),
      pred_row(ACT_PUSH_FRONT, 32'sd0),
      pred_row(ACT_SORTED, 32'sh80000001),
      fixed_row(ACT_SORTED, 32'sd5, 0, 1'b0, ST_FULL, CAPACITY),
      fixed_row(ACT_PUSH_FRONT, -32'sd5, 0, 1'b0, ST_FULL, CAPACITY),
      fixed_row(ACT_PUSH_BACK, 32'sh80000000, 0, 1'b0, ST_FULL, CAPACITY),
      pred_row(ACT_POP_FRONT, -32'sd1),
      pred_row(ACT_POP_BACK, 32'sh7FFFFFFF)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].act, directed_rows[i].val, directed_rows[i].fixed,
                directed_rows[i].res);
    end
    wait_results_done();

    // random part: alternate between filling and draining runs
    filling = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 20; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(0, 29) == 0 ||
            (filling && held_values.size() == CAPACITY && $urandom_range(0, 3) == 0) ||
            (!filling && held_values.size() == 0 && $urandom_range(0, 3) == 0)) begin
          filling = !filling;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          case ($urandom_range(0, 2))
            0: act = ACT_RSVD_5;
            1: act = ACT_RSVD_6;
            default: act = ACT_RSVD_7;
          endcase
        end else if (filling ? (roll < 78) : (roll < 25)) begin
          case ($urandom_range(0, 3))
            0: act = ACT_PUSH_FRONT;
            1: act = ACT_PUSH_BACK;
            default: act = ACT_SORTED;
          endcase
        end else begin
          act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
        end
        // narrow values to get ties, some near the extremes, the rest full range
        case ($urandom_range(0, 9))
          0, 1, 2, 3: val = $signed($urandom_range(0, 16)) - 8;
          4: val = ($urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000)
                   + $signed($urandom_range(0, 2)) - 1;
          default: val = $urandom();
        endcase
        send_item(act, val, 1'b0, '0);
      end
      wait_results_done();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("** sorted_list_deque_unit: PASSED **");
    end else begin
      $display("** sorted_list_deque_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
sv/slq_pkg.sv
sv/slq_in_if.sv
sv/slq_out_if.sv
sv/slq_cell.sv
sv/sorted_list_deque_unit.sv
tb/tb_sorted_list_deque_unit.sv
